/* src/aot_pkg.sv */
package aot_pkg;

    localparam int LETTER_W = 5;
    localparam int ALPHA_W  = 5;

    typedef enum logic [2:0] {
        S_RUN,
        S_WAIT,
        S_ROOT,
        S_TOP,
        S_READ,
        S_EMIT
    } aot_state_t;

endpackage

/* src/alien_order_topo_sort.sv */
// Alien dictionary order. Letters of a sorted dictionary arrive one per cycle
// while in_ready is high; each is compared with the same position of the
// previous word (held in a two-word buffer RAM), and the first mismatch of a
// word adds a precedence edge to a successor-list RAM. A request flagged
// end_of_dictionary closes intake: a depth-first sort then walks the graph,
// waiting on each successor RAM read before the edge is inspected, after which
// the reversed postorder is streamed out, one letter per cycle while the
// consumer keeps up, the final one marked by last_letter. All graph state is
// then cleared and a new dictionary may start. Letters past MAX_WORD_LEN of a
// word are ignored; edges touching letters at or above alphabet_size are
// dropped; cycles are not detected.
module alien_order_topo_sort #(
    parameter int MAX_WORD_LEN = 1024,
    parameter int MAX_LETTERS  = 26
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wen,
    input  logic [aot_pkg::ALPHA_W-1:0]   cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [aot_pkg::LETTER_W-1:0]  letter,
    input  logic                          end_of_word,
    input  logic                          end_of_dictionary,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [aot_pkg::LETTER_W-1:0]  order_letter,
    output logic                          last_letter
);

    localparam int LW  = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;
    localparam int KW  = LW + 1;
    localparam int PW  = $clog2(MAX_WORD_LEN + 1);
    localparam int AW  = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int WD  = 2 * (2 ** AW);
    localparam int SD  = 2 ** (2 * LW);
    localparam int LTW = aot_pkg::LETTER_W;

    aot_pkg::aot_state_t state_reg, state_next;

    logic [aot_pkg::ALPHA_W-1:0] alpha_reg;
    logic [KW-1:0]               k_w;

    // intake
    logic          bufsel_reg;
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] prev_len_reg;
    logic          first_reg;
    logic          acc;
    logic          in_word;
    logic          cmp_en;
    logic [PW-1:0] pos_inc;

    logic           s2_valid_reg;
    logic [LTW-1:0] s2_letter_reg;
    logic           s2_cmp_reg;
    logic           s2_eow_reg;
    logic           mism_reg;
    logic [LTW-1:0] old_letter;

    // graph
    logic [MAX_LETTERS-1:0] edge_reg [MAX_LETTERS];
    logic [KW-1:0]          cnt_reg  [MAX_LETTERS];
    logic                   hit;
    logic                   in_range;
    logic [LW-1:0]          uu, vv;
    logic                   edge_new;
    logic                   edge_add;
    logic [2*LW-1:0]        s_waddr, s_raddr;
    logic [LW-1:0]          s_rdata;

    // sort
    logic [KW-1:0]          root_reg;
    logic [KW-1:0]          sp_reg;
    logic [KW-1:0]          done_reg;
    logic [MAX_LETTERS-1:0] visited_reg;
    logic [LW-1:0]          node_stk [MAX_LETTERS];
    logic [KW-1:0]          idx_stk  [MAX_LETTERS];
    logic [LW-1:0]          ord_stk  [MAX_LETTERS];
    logic [LW-1:0]          tp;
    logic [LW-1:0]          cur_n;
    logic [KW-1:0]          cur_j;
    logic                   has_succ;
    logic                   root_free;
    logic                   push_ok;

    // output register
    logic           out_valid_reg;
    logic [LTW-1:0] out_letter_reg;
    logic           out_last_reg;
    logic           load;

    assign k_w = (6'(alpha_reg) > 6'(MAX_LETTERS)) ? KW'(MAX_LETTERS) : KW'(alpha_reg);

    assign acc     = in_valid && in_ready;
    assign in_word = pos_reg < PW'(MAX_WORD_LEN);
    assign cmp_en  = !first_reg && in_word && (pos_reg < prev_len_reg);
    assign pos_inc = in_word ? pos_reg + PW'(1) : pos_reg;

    aot_ram #(.WIDTH(LTW), .DEPTH(WD)) u_word_ram (
        .clk   (clk),
        .we    (acc && in_word),
        .waddr ({bufsel_reg, pos_reg[AW-1:0]}),
        .wdata (letter),
        .raddr ({~bufsel_reg, pos_reg[AW-1:0]}),
        .rdata (old_letter)
    );

    assign hit      = s2_valid_reg && s2_cmp_reg && !mism_reg && (old_letter != s2_letter_reg);
    assign in_range = (6'(old_letter) < 6'(k_w)) && (6'(s2_letter_reg) < 6'(k_w));
    assign uu       = LW'(old_letter);
    assign vv       = LW'(s2_letter_reg);
    assign edge_new = hit && in_range && !edge_reg[uu][vv];
    assign edge_add = edge_new && (cnt_reg[uu] < KW'(MAX_LETTERS));
    assign s_waddr  = {uu, cnt_reg[uu][LW-1:0]};

    assign tp        = LW'(sp_reg - KW'(1));
    assign cur_n     = node_stk[tp];
    assign cur_j     = idx_stk[tp];
    assign has_succ  = cur_j < cnt_reg[cur_n];
    assign s_raddr   = {cur_n, cur_j[LW-1:0]};
    assign root_free = !visited_reg[root_reg[LW-1:0]];
    assign push_ok   = (KW'(s_rdata) < k_w) && !visited_reg[s_rdata]
                       && (sp_reg < KW'(MAX_LETTERS));

    aot_ram #(.WIDTH(LW), .DEPTH(SD)) u_succ_ram (
        .clk   (clk),
        .we    (edge_add),
        .waddr (s_waddr),
        .wdata (vv),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    assign load = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            aot_pkg::S_RUN:
            begin
                if (acc && end_of_dictionary)
                begin
                    state_next = aot_pkg::S_WAIT;
                end
            end
            aot_pkg::S_WAIT: state_next = aot_pkg::S_ROOT;
            aot_pkg::S_ROOT:
            begin
                if (root_reg >= k_w)
                begin
                    state_next = aot_pkg::S_EMIT;
                end
                else if (root_free)
                begin
                    state_next = aot_pkg::S_TOP;
                end
            end
            aot_pkg::S_TOP:
            begin
                if (has_succ)
                begin
                    state_next = aot_pkg::S_READ;
                end
                else if (sp_reg == KW'(1))
                begin
                    state_next = aot_pkg::S_ROOT;
                end
            end
            aot_pkg::S_READ: state_next = aot_pkg::S_TOP;
            aot_pkg::S_EMIT:
            begin
                if (done_reg == '0)
                begin
                    state_next = aot_pkg::S_RUN;
                end
            end
            default: state_next = aot_pkg::S_RUN;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == aot_pkg::S_RUN);
    end

    assign out_valid    = out_valid_reg;
    assign order_letter = out_letter_reg;
    assign last_letter  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aot_pkg::S_RUN;
            alpha_reg     <= aot_pkg::ALPHA_W'(26);
            bufsel_reg    <= 1'b0;
            pos_reg       <= '0;
            prev_len_reg  <= '0;
            first_reg     <= 1'b1;
            s2_valid_reg  <= 1'b0;
            mism_reg      <= 1'b0;
            root_reg      <= '0;
            sp_reg        <= '0;
            done_reg      <= '0;
            visited_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_LETTERS; i++)
            begin
                edge_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wen)
            begin
                alpha_reg <= cfg_wdata;
            end

            s2_valid_reg <= acc;
            if (acc)
            begin
                if (end_of_word || end_of_dictionary)
                begin
                    prev_len_reg <= pos_inc;
                    bufsel_reg   <= ~bufsel_reg;
                    pos_reg      <= '0;
                    first_reg    <= 1'b0;
                end
                else
                begin
                    pos_reg <= pos_inc;
                end
            end

            if (s2_valid_reg)
            begin
                if (s2_eow_reg)
                begin
                    mism_reg <= 1'b0;
                end
                else if (hit)
                begin
                    mism_reg <= 1'b1;
                end
            end
            if (edge_new)
            begin
                edge_reg[uu][vv] <= 1'b1;
            end
            if (edge_add)
            begin
                cnt_reg[uu] <= cnt_reg[uu] + KW'(1);
            end

            if (state_reg == aot_pkg::S_EMIT && done_reg != '0 && load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                aot_pkg::S_ROOT:
                begin
                    if (root_reg < k_w)
                    begin
                        root_reg <= root_reg + KW'(1);
                        if (root_free)
                        begin
                            visited_reg[root_reg[LW-1:0]] <= 1'b1;
                            sp_reg <= KW'(1);
                        end
                    end
                end
                aot_pkg::S_TOP:
                begin
                    if (!has_succ)
                    begin
                        sp_reg   <= sp_reg - KW'(1);
                        done_reg <= done_reg + KW'(1);
                    end
                end
                aot_pkg::S_READ:
                begin
                    if (push_ok)
                    begin
                        visited_reg[s_rdata] <= 1'b1;
                        sp_reg <= sp_reg + KW'(1);
                    end
                end
                aot_pkg::S_EMIT:
                begin
                    if (done_reg == '0)
                    begin
                        // sort finished: drop the whole graph for the next dictionary
                        bufsel_reg   <= 1'b0;
                        pos_reg      <= '0;
                        prev_len_reg <= '0;
                        first_reg    <= 1'b1;
                        mism_reg     <= 1'b0;
                        root_reg     <= '0;
                        sp_reg       <= '0;
                        visited_reg  <= '0;
                        for (int i = 0; i < MAX_LETTERS; i++)
                        begin
                            edge_reg[i] <= '0;
                            cnt_reg[i]  <= '0;
                        end
                    end
                    else if (load)
                    begin
                        done_reg <= done_reg - KW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s2_letter_reg <= letter;
            s2_cmp_reg    <= cmp_en;
            s2_eow_reg    <= end_of_word || end_of_dictionary;
        end
        case (state_reg)
            aot_pkg::S_ROOT:
            begin
                node_stk[0] <= root_reg[LW-1:0];
                idx_stk[0]  <= '0;
            end
            aot_pkg::S_TOP:
            begin
                if (has_succ)
                begin
                    idx_stk[tp] <= cur_j + KW'(1);
                end
                else
                begin
                    ord_stk[LW'(done_reg)] <= cur_n;
                end
            end
            aot_pkg::S_READ:
            begin
                if (push_ok)
                begin
                    node_stk[LW'(sp_reg)] <= s_rdata;
                    idx_stk[LW'(sp_reg)]  <= '0;
                end
            end
            aot_pkg::S_EMIT:
            begin
                if (done_reg != '0 && load)
                begin
                    out_letter_reg <= LTW'(ord_stk[LW'(done_reg - KW'(1))]);
                    out_last_reg   <= (done_reg == KW'(1));
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* src/aot_ram.sv */
module aot_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/aot_checker.sv */
module aot_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       end_of_dictionary,
    input logic       out_valid,
    input logic       out_ready,
    input logic [4:0] order_letter,
    input logic       last_letter
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(order_letter) && $stable(last_letter))
        else $error("result changed while stalled");

    // intake stays closed once end_of_dictionary is accepted, while the sort begins
    a_eod_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && end_of_dictionary |=> !in_ready ##1 !in_ready)
        else $error("intake open during sort");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid || rst_n)
        else $error("result present after reset");

endmodule

bind alien_order_topo_sort aot_checker u_aot_checker (.*);
